// ===== rtl/imm_pkg.sv =====
`timescale 1ns / 1ps

package imm_pkg;

   localparam int MAX_DIM     = 64;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 38;
   localparam int MUL_W       = 2 * ELEM_W;
   localparam int DIM_W       = 7;
   localparam int IDX_W       = 6;
   localparam int ADDR_W      = 12;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int CSR_IDX_W   = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_SECOND = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_SECOND = 2'd3;

   // Input word commands.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_STREAM = 1'b1;

   typedef struct packed {
      logic                     command;
      logic signed [ELEM_W-1:0] element;
   } imm_req_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] product;
      logic [IDX_W-1:0]         row_index;
      logic [IDX_W-1:0]         col_index;
      logic                     row_last;
      logic                     matrix_last;
      logic                     size_error;
   } imm_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              store_we;
      logic [ADDR_W-1:0] store_addr;
      logic              capture;
      logic              mac_issue;
      logic [ADDR_W-1:0] mac_addr;
      logic [IDX_W-1:0]  col;
      logic              emit_issue;
      logic [IDX_W-1:0]  emit_row;
      logic              emit_row_last;
      logic              emit_matrix_last;
      logic              emit_error;
      logic              clear_acc;
   } imm_cmd_type;

   // A dimension of zero acts as one, anything above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = v;
      return r;
   endfunction

endpackage

// ===== rtl/imm_ctrl.sv =====
`timescale 1ns / 1ps

module imm_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                command,
   input  logic [imm_pkg::DIM_W-1:0]           rows_first,
   input  logic [imm_pkg::DIM_W-1:0]           cols_first,
   input  logic [imm_pkg::DIM_W-1:0]           rows_second,
   input  logic [imm_pkg::DIM_W-1:0]           cols_second,
   output logic                                busy,
   output imm_pkg::imm_cmd_type                cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam int DW = imm_pkg::DIM_W;
   localparam int IW = imm_pkg::IDX_W;
   localparam int AW = imm_pkg::ADDR_W;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] load_ff, load_in;
   logic [IW-1:0] inner_ff, inner_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] j_ff, j_in;
   logic          drain_ff, drain_in;
   logic [AW-1:0] base_ff, base_in;
   logic          rend_ff, rend_in;
   logic          err_ff, err_in;
   logic          ml_ff, ml_in;
   logic [IW-1:0] erow_ff, erow_in;

   logic              accept;
   logic              match;
   logic              do_mac;
   logic              row_end;
   logic              mlast;
   logic              j_last;
   logic [DW-1:0]     inner_next;
   logic [DW-1:0]     row_next;
   logic [DW-1:0]     j_next;
   logic [AW:0]       load_next;
   logic [2*DW-1:0]   load_limit;
   logic [IW+DW-1:0]  base_prod;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && (state_ff == ST_IDLE);
   assign match      = (cols_first == rows_second);
   assign inner_next = {1'b0, inner_ff} + DW'(1);
   assign row_next   = {1'b0, row_ff} + DW'(1);
   assign j_next     = {1'b0, j_ff} + DW'(1);
   assign row_end    = (inner_next >= cols_first);
   assign mlast      = (row_next >= rows_first);
   assign do_mac     = match && ({1'b0, inner_ff} < rows_second);
   assign j_last     = (j_next >= cols_second);
   assign load_next  = {1'b0, load_ff} + (AW+1)'(1);
   assign load_limit = rows_second * cols_second;
   assign base_prod  = inner_ff * cols_second;

   always_comb begin
      state_in = state_ff;
      load_in  = load_ff;
      inner_in = inner_ff;
      row_in   = row_ff;
      j_in     = j_ff;
      drain_in = drain_ff;
      base_in  = base_ff;
      rend_in  = rend_ff;
      err_in   = err_ff;
      ml_in    = ml_ff;
      erow_in  = erow_ff;

      cmd                  = '0;
      cmd.store_addr       = load_ff;
      cmd.mac_addr         = base_ff + AW'(j_ff);
      cmd.col              = j_ff;
      cmd.emit_row         = erow_ff;
      cmd.emit_error       = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (command == imm_pkg::CMD_LOAD)) begin
               cmd.store_we = 1'b1;
               if ((2*DW)'(load_next) >= load_limit) load_in = '0;
               else load_in = load_next[AW-1:0];
            end else if (accept) begin
               cmd.capture = 1'b1;
               base_in     = AW'(base_prod);
               j_in        = '0;
               drain_in    = 1'b0;
               rend_in     = row_end;
               inner_in    = row_end ? '0 : inner_next[IW-1:0];
               if (row_end) begin
                  erow_in = row_ff;
                  ml_in   = mlast;
                  err_in  = !match;
                  row_in  = mlast ? '0 : row_next[IW-1:0];
               end
               if (do_mac) state_in = ST_MAC;
               else if (row_end) state_in = ST_EMIT;
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            if (j_last) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end else begin
               j_in = j_next[IW-1:0];
            end
         end
         ST_DRAIN: begin
            // The drain state lets the last accumulator write land before any read.
            if (drain_ff) begin
               state_in = rend_ff ? ST_EMIT : ST_IDLE;
               j_in     = '0;
            end else begin
               drain_in = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit_issue       = 1'b1;
            cmd.col              = err_ff ? '0 : j_ff;
            cmd.emit_row_last    = err_ff || j_last;
            cmd.emit_matrix_last = (err_ff || j_last) && ml_ff;
            if (err_ff || j_last) begin
               cmd.clear_acc = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               j_in = j_next[IW-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         load_ff  <= '0;
         inner_ff <= '0;
         row_ff   <= '0;
         j_ff     <= '0;
         drain_ff <= 1'b0;
         rend_ff  <= 1'b0;
         err_ff   <= 1'b0;
         ml_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         inner_ff <= inner_in;
         row_ff   <= row_in;
         j_ff     <= j_in;
         drain_ff <= drain_in;
         rend_ff  <= rend_in;
         err_ff   <= err_in;
         ml_ff    <= ml_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      erow_ff <= erow_in;
   end

endmodule

// ===== rtl/imm_datapath.sv =====
`timescale 1ns / 1ps

module imm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  imm_pkg::imm_req_type req_word,
   input  imm_pkg::imm_cmd_type cmd,
   output logic                 rsp_strobe,
   output imm_pkg::imm_rsp_type rsp_word
);

   localparam int EW = imm_pkg::ELEM_W;
   localparam int PW = imm_pkg::PROD_W;
   localparam int MW = imm_pkg::MUL_W;
   localparam int IW = imm_pkg::IDX_W;

   logic signed [EW-1:0] store_mem [imm_pkg::STORE_DEPTH];
   logic [PW-1:0]        acc_mem   [imm_pkg::MAX_DIM];
   logic [imm_pkg::MAX_DIM-1:0] acc_valid_ff;

   logic signed [EW-1:0] a_ff;
   logic signed [EW-1:0] b_rd_ff;
   logic [PW-1:0]        acc_rd_ff;
   logic                 s1_accv_ff;
   logic                 s1_mac_ff;
   logic [IW-1:0]        s1_col_ff;

   logic                 e1_valid_ff;
   logic [IW-1:0]        e1_row_ff;
   logic [IW-1:0]        e1_col_ff;
   logic                 e1_rl_ff;
   logic                 e1_ml_ff;
   logic                 e1_err_ff;

   logic signed [MW-1:0] prod_ff, prod_in;
   logic [PW-1:0]        s2_acc_ff, s2_acc_in;
   logic                 s2_valid_ff;
   logic [IW-1:0]        s2_col_ff;
   logic [PW-1:0]        sum;

   logic                 rsp_strobe_ff;
   imm_pkg::imm_rsp_type rsp_word_ff, rsp_word_in;

   assign prod_in   = a_ff * b_rd_ff;
   assign s2_acc_in = s1_accv_ff ? acc_rd_ff : '0;
   assign sum       = s2_acc_ff + {{(PW-MW){prod_ff[MW-1]}}, prod_ff};

   always_comb begin
      rsp_word_in             = '0;
      rsp_word_in.product     = (s1_accv_ff && !e1_err_ff) ? acc_rd_ff : '0;
      rsp_word_in.row_index   = e1_row_ff;
      rsp_word_in.col_index   = e1_col_ff;
      rsp_word_in.row_last    = e1_rl_ff;
      rsp_word_in.matrix_last = e1_ml_ff;
      rsp_word_in.size_error  = e1_err_ff;
   end

   // Second-matrix store, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.store_we) store_mem[cmd.store_addr] <= req_word.element;
      b_rd_ff <= store_mem[cmd.mac_addr];
   end

   // Column accumulators: read at issue, written back from the prod_ff and s2_acc_ff stage.
   always_ff @(posedge clock) begin
      if (s2_valid_ff) acc_mem[s2_col_ff] <= sum;
      acc_rd_ff <= acc_mem[cmd.col];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) a_ff <= req_word.element;
      s1_col_ff   <= cmd.col;
      e1_row_ff   <= cmd.emit_row;
      e1_col_ff   <= cmd.col;
      e1_rl_ff    <= cmd.emit_row_last;
      e1_ml_ff    <= cmd.emit_matrix_last;
      e1_err_ff   <= cmd.emit_error;
      prod_ff     <= prod_in;
      s2_acc_ff   <= s2_acc_in;
      s2_col_ff   <= s1_col_ff;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff  <= '0;
         s1_accv_ff    <= 1'b0;
         s1_mac_ff     <= 1'b0;
         e1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_accv_ff    <= acc_valid_ff[cmd.col];
         s1_mac_ff     <= cmd.mac_issue;
         e1_valid_ff   <= cmd.emit_issue;
         s2_valid_ff   <= s1_mac_ff;
         rsp_strobe_ff <= e1_valid_ff;
         // An accumulator without its valid bit reads as zero.
         if (cmd.clear_acc) acc_valid_ff <= '0;
         else if (s2_valid_ff) acc_valid_ff[s2_col_ff] <= 1'b1;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Load words (command 0) go to the store; busy stays low and the next word may follow.
// A stream word is captured; the single multiply-accumulate unit then works through each
// column, then a drain state (both skipped if inner sizes differ); at a row end the
// product row is issued (one word on a size error), registered, one result per cycle.
// The receiver cannot stall. Synchronous active-high reset clears counters and flags and
// sets all dimensions to 1; the second-matrix store is not cleared and holds garbage.

module integer_matrix_multiply (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  imm_pkg::imm_req_type                req_word,
   output logic                                rsp_strobe,
   output imm_pkg::imm_rsp_type                rsp_word,
   input  logic                                csr_write_enable,
   input  logic [imm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [imm_pkg::DIM_W-1:0]           csr_write_data
);

   logic [imm_pkg::DIM_W-1:0] rows_first_ff;
   logic [imm_pkg::DIM_W-1:0] cols_first_ff;
   logic [imm_pkg::DIM_W-1:0] rows_second_ff;
   logic [imm_pkg::DIM_W-1:0] cols_second_ff;
   imm_pkg::imm_cmd_type      cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_first_ff  <= imm_pkg::DIM_W'(1);
         cols_first_ff  <= imm_pkg::DIM_W'(1);
         rows_second_ff <= imm_pkg::DIM_W'(1);
         cols_second_ff <= imm_pkg::DIM_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            imm_pkg::REG_ROWS_FIRST:  rows_first_ff  <= csr_write_data;
            imm_pkg::REG_COLS_FIRST:  cols_first_ff  <= csr_write_data;
            imm_pkg::REG_ROWS_SECOND: rows_second_ff <= csr_write_data;
            imm_pkg::REG_COLS_SECOND: cols_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   imm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .command     (req_word.command),
      .rows_first  (imm_pkg::dim_clamp(rows_first_ff)),
      .cols_first  (imm_pkg::dim_clamp(cols_first_ff)),
      .rows_second (imm_pkg::dim_clamp(rows_second_ff)),
      .cols_second (imm_pkg::dim_clamp(cols_second_ff)),
      .busy        (busy),
      .cmd         (cmd)
   );

   imm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
